>>> sv/bas_pkg.sv
// Shared constants, codes and types of the bidirectional-average SAD core.
package bas_pkg;

	localparam int LANES      = 8;
	localparam int PIX_W      = 8;
	localparam int MAX_HEIGHT = 128;

	localparam int BUS_W     = LANES * PIX_W;
	localparam int DIFF_W    = PIX_W;
	localparam int TREE_W    = DIFF_W + $clog2(LANES);
	localparam int SUM_W     = 21;
	localparam int WIDTH_W   = 7;
	localparam int HEIGHT_W  = 8;
	localparam int CFG_W     = 8;
	localparam int IDX_W     = 1;
	localparam int GROUP_W   = 3;
	localparam int NGROUP_W  = GROUP_W + 1;
	localparam int LANE_SH   = $clog2(LANES);

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Supported row widths; the two zero-result widths are counted but not summed.
	localparam logic [WIDTH_W-1:0] WIDTH_4    = 7'd4;
	localparam logic [WIDTH_W-1:0] WIDTH_8    = 7'd8;
	localparam logic [WIDTH_W-1:0] WIDTH_16   = 7'd16;
	localparam logic [WIDTH_W-1:0] WIDTH_24   = 7'd24;
	localparam logic [WIDTH_W-1:0] WIDTH_32   = 7'd32;
	localparam logic [WIDTH_W-1:0] WIDTH_48   = 7'd48;
	localparam logic [WIDTH_W-1:0] WIDTH_64   = 7'd64;
	localparam logic [WIDTH_W-1:0] WIDTH_Z40  = 7'd40;
	localparam logic [WIDTH_W-1:0] WIDTH_Z56  = 7'd56;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_8;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 8'd8;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_WIDTH  = 1'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 1'd1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_ZERO    = 2'd1;
	localparam logic [1:0] STATUS_ILLEGAL = 2'd2;

	typedef struct packed {
		logic       acc_en;
		logic       emit;
		logic [1:0] status;
	} ctrl_t;

	typedef logic [DIFF_W-1:0] diff_t;

endpackage

>>> sv/bas_lane.sv
// One pixel lane: rounded reference average and registered absolute difference.
module bas_lane
	import bas_pkg::*;
(
	input  logic             clk,
	input  logic             adv,
	input  logic             active,
	input  logic [PIX_W-1:0] src,
	input  logic [PIX_W-1:0] ref1,
	input  logic [PIX_W-1:0] ref2,
	output diff_t            diff_s1
);

	logic [PIX_W:0]   pair_sum;
	logic [PIX_W-1:0] avg;
	diff_t            diff;

	always_comb begin
		pair_sum = {1'b0, ref1} + {1'b0, ref2} + {{PIX_W{1'b0}}, 1'b1};
		avg      = pair_sum[PIX_W:1];
		if (!active) begin
			diff = '0;
		end else if (src > avg) begin
			diff = src - avg;
		end else begin
			diff = avg - src;
		end
	end

	// Payload register: no reset needed.
	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1 <= diff;
		end
	end

endmodule

>>> sv/bas_merge.sv
// Merge stage: sum the lane differences, accumulate the block, hold the result.
module bas_merge
	import bas_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             adv,
	input  logic             valid_s1,
	input  ctrl_t            ctrl_s1,
	input  diff_t            diff_s1 [LANES],
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SUM_W-1:0] sad_sum,
	output logic [1:0]       status
);

	logic [TREE_W-1:0] tree_sum;
	logic [SUM_W:0]    acc_wide;
	logic [SUM_W-1:0]  acc_next;
	logic [SUM_W-1:0]  acc_q;

	always_comb begin
		tree_sum = '0;
		for (int i = 0; i < LANES; i++) begin
			tree_sum = tree_sum + TREE_W'(diff_s1[i]);
		end
		acc_wide = {1'b0, acc_q} + (SUM_W+1)'(tree_sum);
		if (!ctrl_s1.acc_en) begin
			acc_next = acc_q;
		end else if (acc_wide > {1'b0, SUM_MAX}) begin
			acc_next = SUM_MAX;
		end else begin
			acc_next = acc_wide[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (clr) begin
				acc_q <= '0;
			end else if (adv && valid_s1) begin
				// Close the block on emit, otherwise keep accumulating.
				acc_q <= ctrl_s1.emit ? '0 : acc_next;
			end
			if (adv && valid_s1 && ctrl_s1.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && ctrl_s1.emit) begin
			sad_sum <= (ctrl_s1.status == STATUS_OK) ? acc_next : '0;
			status  <= ctrl_s1.status;
		end
	end

endmodule

>>> sv/bipred_average_sad_core.sv
// Top level of the bidirectional-average SAD core.
//
// Input channel (in_valid/in_ready) carries one group of eight pixels per
// request: source, first and second reference, lane 0 in the low byte. A row
// of block_width pixels takes ceil(block_width/8) requests; width 4 uses the
// low four lanes. After the last request of the last row one result request
// leaves on the output channel (out_valid/out_ready): sad_sum and status.
// A bad width or height turns every request into a block of its own that
// returns sum 0 with status 2; widths 40 and 56 return sum 0 with status 1.
// Throughput: one request per cycle while no stall holds the block, set by the
// eight lane units that work side by side and the merge adder. The block's
// last request goes into the lane registers at the accepting edge, then into
// the result register in the merge stage, which drives the output.
// A cfg_we write (idle only) updates a register and restarts the block.
// Reset restores width 8 and height 8, clears counters, sum and result valid.
// When the receiver stalls with a result pending, the block keeps taking
// requests until a second result reaches the merge stage; it then holds.
module bipred_average_sad_core
	import bas_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [BUS_W-1:0]    src_pixels,
	input  logic [BUS_W-1:0]    ref1_pixels,
	input  logic [BUS_W-1:0]    ref2_pixels,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SUM_W-1:0]    sad_sum,
	output logic [1:0]          status
);

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [GROUP_W-1:0]  group_q;
	logic [HEIGHT_W-1:0] row_q;

	logic                valid_s1;
	ctrl_t               ctrl_s1;
	diff_t               diff_s1 [LANES];

	logic                stall;
	logic                adv;
	logic                accept;
	logic                width_ok;
	logic                height_ok;
	logic                legal;
	logic                zero_w;
	logic [WIDTH_W-1:0]  width_round;
	logic [NGROUP_W-1:0] groups;
	logic                group_last;
	logic                row_last;
	logic                block_end;
	logic [LANES-1:0]    active;
	ctrl_t               ctrl;

	// Hold everything only when a second result would overwrite a pending one.
	assign stall  = valid_s1 && ctrl_s1.emit && out_valid && !out_ready;
	assign adv    = !stall;
	assign in_ready = adv;
	assign accept = in_valid && in_ready;

	// Geometry decode from the configuration registers.
	always_comb begin
		width_ok = (width_q == WIDTH_4)   || (width_q == WIDTH_8)   ||
		           (width_q == WIDTH_16)  || (width_q == WIDTH_24)  ||
		           (width_q == WIDTH_32)  || (width_q == WIDTH_48)  ||
		           (width_q == WIDTH_64)  || (width_q == WIDTH_Z40) ||
		           (width_q == WIDTH_Z56);
		height_ok = (height_q >= HEIGHT_W'(2)) && !height_q[0] &&
		            ({1'b0, height_q} <= (HEIGHT_W+1)'(MAX_HEIGHT)) &&
		            !((width_q == WIDTH_8) && height_q[1]);
		legal  = width_ok && height_ok;
		zero_w = (width_q == WIDTH_Z40) || (width_q == WIDTH_Z56);

		width_round = width_q + WIDTH_W'(LANES - 1);
		groups      = NGROUP_W'(width_round >> LANE_SH);
		group_last  = ({1'b0, group_q} + NGROUP_W'(1)) >= groups;
		row_last    = ({1'b0, row_q} + (HEIGHT_W+1)'(1)) >= {1'b0, height_q};
		block_end   = group_last && row_last;

		// Width 4 leaves the upper half of the lanes idle.
		for (int i = 0; i < LANES; i++) begin
			active[i] = (width_q != WIDTH_4) || (i < int'(WIDTH_4));
		end

		if (!legal) begin
			ctrl.acc_en = 1'b0;
			ctrl.emit   = 1'b1;
			ctrl.status = STATUS_ILLEGAL;
		end else begin
			ctrl.acc_en = !zero_w;
			ctrl.emit   = block_end;
			ctrl.status = zero_w ? STATUS_ZERO : STATUS_OK;
		end
	end

	// Configuration registers and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			group_q  <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				default:    ;
			endcase
			group_q <= '0;
			row_q   <= '0;
		end else if (accept) begin
			if (!legal || block_end) begin
				group_q <= '0;
				row_q   <= '0;
			end else if (group_last) begin
				group_q <= '0;
				row_q   <= row_q + HEIGHT_W'(1);
			end else begin
				group_q <= group_q + GROUP_W'(1);
			end
		end
	end

	// Stage 1 control travels beside the lane registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctrl_s1  <= '0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			ctrl_s1  <= ctrl;
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		bas_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.active  (active[g]),
			.src     (src_pixels[g*PIX_W +: PIX_W]),
			.ref1    (ref1_pixels[g*PIX_W +: PIX_W]),
			.ref2    (ref2_pixels[g*PIX_W +: PIX_W]),
			.diff_s1 (diff_s1[g])
		);
	end

	bas_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (cfg_we),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.ctrl_s1   (ctrl_s1),
		.diff_s1   (diff_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sad_sum   (sad_sum),
		.status    (status)
	);

endmodule

>>> tb/sv/tb_bipred_average_sad_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bidirectional-average SAD core.
module tb_bipred_average_sad_core;
	import bas_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RST_CYCLES    = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 1000;
	// Quiet margin after the last result is taken.
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int PRESSURE_REQS = 24;

	localparam logic [BUS_W-1:0] PIX_ONES  = '1;
	localparam logic [BUS_W-1:0] PIX_ZEROS = '0;

	typedef struct packed {
		logic [SUM_W-1:0] sad;
		logic [1:0]       code;
	} sad_result_t;

	typedef enum logic {ROW_CFG, ROW_GROUP} row_kind_e;

	// One line of the directed plan: a register write or a pixel group, the
	// latter optionally with its result spelled out by hand.
	typedef struct {
		row_kind_e          kind;
		logic [IDX_W-1:0]   idx;
		logic [CFG_W-1:0]   data;
		logic [BUS_W-1:0]   src;
		logic [BUS_W-1:0]   r1;
		logic [BUS_W-1:0]   r2;
		bit                 known;
		sad_result_t        res;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [BUS_W-1:0]   src_pixels;
	logic [BUS_W-1:0]   ref1_pixels;
	logic [BUS_W-1:0]   ref2_pixels;
	logic               out_valid;
	logic               out_ready;
	logic [SUM_W-1:0]   sad_sum;
	logic [1:0]         status;

	bipred_average_sad_core DUT (.*);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Shadow copy of the block: geometry registers and block progress.
	logic [WIDTH_W-1:0]  cur_width;
	logic [HEIGHT_W-1:0] cur_height;
	int unsigned         run_sad;
	int unsigned         cur_group;
	int unsigned         rows_done;

	sad_result_t pending_sums[$];
	int          errors = 0;
	int unsigned cycle_count = 0;
	// calm: neither side idles; hold_req: ask the receiver for a long hold-off
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;

	function automatic void restart_block();
		run_sad   = 0;
		cur_group = 0;
		rows_done = 0;
	endfunction

	function automatic void apply_reg(input logic [IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		case (idx)
			REG_WIDTH:  cur_width  = data[WIDTH_W-1:0];
			REG_HEIGHT: cur_height = data[HEIGHT_W-1:0];
			default: ;
		endcase
		// any write throws away the block in progress
		restart_block();
	endfunction

	function automatic bit geometry_ok();
		case (cur_width)
			WIDTH_4, WIDTH_8, WIDTH_16, WIDTH_24, WIDTH_32, WIDTH_48, WIDTH_64,
			WIDTH_Z40, WIDTH_Z56: ;
			default: return 1'b0;
		endcase
		if (cur_height < 2 || cur_height[0] || cur_height > MAX_HEIGHT)
			return 1'b0;
		// width 8 needs a height that is a multiple of four
		if (cur_width == WIDTH_8 && cur_height[1])
			return 1'b0;
		return 1'b1;
	endfunction

	// SAD of one group against the rounded-up average of the two references.
	function automatic int unsigned group_sad(input logic [BUS_W-1:0] s, r1, r2,
			input int unsigned lanes);
		int unsigned a, b, c, avg, acc;
		acc = 0;
		for (int i = 0; i < LANES; i++) begin
			if (i < lanes) begin
				a   = s[i*PIX_W +: PIX_W];
				b   = r1[i*PIX_W +: PIX_W];
				c   = r2[i*PIX_W +: PIX_W];
				avg = (b + c + 1) >> 1;
				acc += (a > avg) ? a - avg : avg - a;
			end
		end
		return acc;
	endfunction

	// Advance the shadow block by one accepted group; returns 1 with the
	// block result when this group closes a block.
	function automatic bit avg_sad_step(input logic [BUS_W-1:0] s, r1, r2,
			output sad_result_t res);
		int unsigned w, groups, start, lanes;
		bit zero_w;
		res = '0;
		if (!geometry_ok()) begin
			// bad geometry: every request is a block of its own
			restart_block();
			res.code = STATUS_ILLEGAL;
			return 1'b1;
		end
		w      = cur_width;
		zero_w = (cur_width == WIDTH_Z40) || (cur_width == WIDTH_Z56);
		groups = (w + LANES - 1) >> LANE_SH;
		start  = cur_group * LANES;
		lanes  = (w > start) ? w - start : 0;
		if (lanes > LANES)
			lanes = LANES;
		if (!zero_w) begin
			run_sad += group_sad(s, r1, r2, lanes);
			if (run_sad > SUM_MAX)
				run_sad = SUM_MAX;
		end
		cur_group++;
		if (cur_group >= groups) begin
			cur_group = 0;
			rows_done++;
			if (rows_done >= cur_height) begin
				res.sad  = zero_w ? '0 : run_sad[SUM_W-1:0];
				res.code = zero_w ? STATUS_ZERO : STATUS_OK;
				restart_block();
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic int idle_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Pixel bus with a bias toward black and white lanes.
	function automatic logic [BUS_W-1:0] rand_bus();
		logic [BUS_W-1:0] bus;
		for (int i = 0; i < LANES; i++) begin
			case ($urandom_range(0, 4))
				0:       bus[i*PIX_W +: PIX_W] = '0;
				1:       bus[i*PIX_W +: PIX_W] = '1;
				default: bus[i*PIX_W +: PIX_W] = PIX_W'($urandom_range(0, 255));
			endcase
		end
		return bus;
	endfunction

	function automatic logic [WIDTH_W-1:0] pick_width();
		case ($urandom_range(0, 6))
			0:       return WIDTH_4;
			1:       return WIDTH_8;
			2:       return WIDTH_16;
			3:       return WIDTH_24;
			4:       return WIDTH_32;
			5:       return WIDTH_48;
			default: return WIDTH_64;
		endcase
	endfunction

	function automatic plan_row_t cfg_row(input logic [IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		plan_row_t row;
		row       = '{kind: ROW_CFG, default: '0};
		row.kind  = ROW_CFG;
		row.idx   = idx;
		row.data  = data;
		return row;
	endfunction

	function automatic plan_row_t plain_row(input logic [BUS_W-1:0] s, r1, r2);
		plan_row_t row;
		row      = '{kind: ROW_GROUP, default: '0};
		row.kind = ROW_GROUP;
		row.src  = s;
		row.r1   = r1;
		row.r2   = r2;
		return row;
	endfunction

	function automatic plan_row_t known_row(input logic [BUS_W-1:0] s, r1, r2,
			input logic [SUM_W-1:0] sad, input logic [1:0] code);
		plan_row_t row;
		row          = plain_row(s, r1, r2);
		row.known    = 1'b1;
		row.res.sad  = sad;
		row.res.code = code;
		return row;
	endfunction

	// Offer one group; hold valid and payload until accepted, then predict.
	task automatic offer_group(input logic [BUS_W-1:0] s, r1, r2,
			input bit known, input sad_result_t known_res);
		int gap;
		bit has_res;
		sad_result_t res;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		src_pixels  <= s;
		ref1_pixels <= r1;
		ref2_pixels <= r2;
		do
			@(posedge clk);
		while (!in_ready);
		has_res = avg_sad_step(s, r1, r2, res);
		if (known)
			pending_sums.push_back(known_res);
		else if (has_res)
			pending_sums.push_back(res);
	endtask

	// Register writes only with the block drained and quiet.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, data);
	endtask

	// Receiver: random back-pressure, long hold-off on request, and checks.
	initial begin
		int stall_left;
		int r;
		sad_result_t want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_sums.size() == 0) begin
					$error("unexpected result: sad_sum %0d status %0d", sad_sum, status);
					errors++;
				end else begin
					want = pending_sums.pop_front();
					if (sad_sum !== want.sad) begin
						$error("sad_sum mismatch: expected %0d, got %0d", want.sad, sad_sum);
						errors++;
					end
					if (status !== want.code) begin
						$error("status mismatch: expected %0d, got %0d", want.code, status);
						errors++;
					end
				end
			end
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_ready <= 1'b1;
				end else if (r < 97) begin
					out_ready <= 1'b0;
				end else begin
					stall_left = $urandom_range(8, 40);
					out_ready <= 1'b0;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		plan_row_t plan[$];
		sad_result_t none;
		int kind, items, per, blocks;
		int unsigned random_items;
		bit tall, wide_first;
		logic [WIDTH_W-1:0] w;
		logic [HEIGHT_W-1:0] h;
		logic [CFG_W-1:0] w_data;

		none         = '0;
		random_items = 0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_WIDTH;
		cfg_data     = '0;
		in_valid     = 1'b0;
		src_pixels   = '0;
		ref1_pixels  = '0;
		ref2_pixels  = '0;
		out_ready    = 1'b0;

		// Directed plan. Reset geometry is 8x8: eight requests per block, and
		// white source over black references costs 255 per pixel.
		for (int i = 0; i < 7; i++)
			plan.push_back(plain_row(PIX_ONES, PIX_ZEROS, PIX_ZEROS));
		plan.push_back(known_row(PIX_ONES, PIX_ZEROS, PIX_ZEROS, 21'd16320, STATUS_OK));
		// Smallest block, 4x2; the width byte carries a stray top bit that the
		// register drops. Upper lanes hold junk that must not count.
		plan.push_back(cfg_row(REG_HEIGHT, 8'd2));
		plan.push_back(cfg_row(REG_WIDTH, 8'h84));
		plan.push_back(plain_row(64'hA5A5A5A5_00000000, PIX_ONES, PIX_ONES));
		// (0 + 1 + 1) >> 1 rounds up to 1: four lanes add 4 to 1020
		plan.push_back(known_row(64'h5A5A5A5A_00000000, PIX_ZEROS,
			64'h00000000_01010101, 21'd1024, STATUS_OK));
		// Rewrite a register mid-block: the partial sum must be dropped.
		plan.push_back(plain_row(PIX_ZEROS, PIX_ONES, PIX_ONES));
		plan.push_back(cfg_row(REG_HEIGHT, 8'd2));
		plan.push_back(plain_row(64'h00000000_80FF0100, 64'h00000000_7FFE0001,
			64'h00000000_80FF0102));
		plan.push_back(plain_row(PIX_ONES, PIX_ZEROS, PIX_ONES));
		// Width 40: five requests per row are consumed, the sum is forced to zero.
		plan.push_back(cfg_row(REG_WIDTH, 8'd40));
		for (int i = 0; i < 9; i++)
			plan.push_back(plain_row(PIX_ONES, PIX_ZEROS, PIX_ZEROS));
		plan.push_back(known_row(PIX_ONES, PIX_ZEROS, PIX_ZEROS, 21'd0, STATUS_ZERO));
		// Bad geometry: width 0, odd height, width 8 with height 6, height 255.
		plan.push_back(cfg_row(REG_WIDTH, 8'h80));
		plan.push_back(known_row(PIX_ONES, PIX_ZEROS, PIX_ZEROS, 21'd0, STATUS_ILLEGAL));
		plan.push_back(cfg_row(REG_WIDTH, 8'd16));
		plan.push_back(cfg_row(REG_HEIGHT, 8'd3));
		plan.push_back(known_row(PIX_ONES, PIX_ZEROS, PIX_ZEROS, 21'd0, STATUS_ILLEGAL));
		plan.push_back(cfg_row(REG_WIDTH, 8'd8));
		plan.push_back(cfg_row(REG_HEIGHT, 8'd6));
		plan.push_back(known_row(PIX_ONES, PIX_ONES, PIX_ONES, 21'd0, STATUS_ILLEGAL));
		plan.push_back(cfg_row(REG_HEIGHT, 8'hFF));
		plan.push_back(known_row(PIX_ZEROS, PIX_ONES, PIX_ONES, 21'd0, STATUS_ILLEGAL));

		// Hold reset, then release on an edge.
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		cur_width  = WIDTH_RESET;
		cur_height = HEIGHT_RESET;
		restart_block();
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].idx, plan[i].data);
			else
				offer_group(plan[i].src, plan[i].r1, plan[i].r2, plan[i].known,
					plan[i].res);
		end

		// Back-pressure: stop the receiver for a long stretch while requests keep
		// coming, so the block fills and drops in_ready.
		write_reg(REG_WIDTH, CFG_W'(WIDTH_4));
		write_reg(REG_HEIGHT, 8'd2);
		calm     = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < PRESSURE_REQS; i++)
			offer_group(rand_bus(), rand_bus(), rand_bus(), 1'b0, none);
		calm = 1'b0;

		// Random phases: mostly whole blocks of legal geometry, with some
		// zero-result widths, bad geometry and blocks cut short by a write.
		while (random_items < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				w     = WIDTH_W'($urandom_range(0, 127));
				h     = HEIGHT_W'($urandom_range(0, 255));
				items = $urandom_range(1, 6);
			end else if (kind < 16) begin
				w     = $urandom_range(0, 1) ? WIDTH_Z40 : WIDTH_Z56;
				h     = HEIGHT_W'(2 * $urandom_range(1, 2));
				items = ((w + LANES - 1) >> LANE_SH) * h * $urandom_range(1, 2);
			end else begin
				w    = pick_width();
				per  = (w == WIDTH_8) ? 4 : 2;
				tall = (w <= WIDTH_16) && ($urandom_range(0, 19) == 0);
				if (tall)
					h = $urandom_range(0, 1) ? HEIGHT_W'(MAX_HEIGHT)
						: HEIGHT_W'(per * $urandom_range(1, MAX_HEIGHT / per));
				else if (w >= WIDTH_32)
					h = HEIGHT_W'(per * $urandom_range(1, 2));
				else
					h = HEIGHT_W'(per * $urandom_range(1, 4));
				per    = ((w + LANES - 1) >> LANE_SH) * h;
				blocks = tall ? 1 : $urandom_range(1, 3);
				items  = per * blocks;
				// leave a partial block for the next write to discard
				if ($urandom_range(0, 3) == 0)
					items += $urandom_range(1, per - 1);
			end
			w_data     = {$urandom_range(0, 1) != 0, w};
			wide_first = $urandom_range(0, 1);
			calm       = ($urandom_range(0, 4) == 0);
			if (wide_first) begin
				write_reg(REG_WIDTH, w_data);
				write_reg(REG_HEIGHT, h);
			end else begin
				write_reg(REG_HEIGHT, h);
				write_reg(REG_WIDTH, w_data);
			end
			for (int k = 0; k < items; k++) begin
				offer_group(rand_bus(), rand_bus(), rand_bus(), 1'b0, none);
				random_items++;
			end
		end
		calm = 1'b0;

		// Drain, then give a late stray result time to show up.
		in_valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
